FILE: design/console_line_editor_assert.svh
// ----------------------------------------------------------------------------
// console line editor assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CLE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define CLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// shared constants and helpers for the console line editor
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  localparam int LINE_DEPTH_DEF = 32;

  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_DEL = 8'h7F;
  localparam logic [7:0] CODE_SP  = 8'h20;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] ENTER_KEY_RST = CODE_CR;

  localparam logic PORT_CONSOLE = 1'b0;
  localparam logic PORT_PEER    = 1'b1;

  // fixed result sequences
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_BS   = 2'd1;
  localparam logic [1:0] KIND_CRLF = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       port;
    logic       last;
  } res_t;

  // one result of a fixed sequence, chosen by kind and step
  function automatic res_t fix_result(input logic [1:0] kind, input logic [1:0] step,
                                      input logic [7:0] echo);
    res_t r;
    r = '{data: echo, port: PORT_CONSOLE, last: 1'b1};
    case (kind)
      KIND_BS: begin
        r.data = (step == 2'd1) ? CODE_SP : CODE_BS;
        r.last = (step == 2'd2);
      end
      KIND_CRLF: begin
        r.data = step[0] ? CODE_LF : CODE_CR;
        r.port = step[1] ? PORT_CONSOLE : PORT_PEER;
        r.last = (step == 2'd3);
      end
      default: begin
        r = '{data: echo, port: PORT_CONSOLE, last: 1'b1};
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor
// line editor between a console link and a peer link
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) takes one received byte with its
//   source in in_req_type. peer bytes are forwarded to the console; console
//   bytes are edited into a line held in a LINE_DEPTH-entry ram.
//   result channel (out_valid / out_stall) gives each result byte with
//   its destination port; out_last marks the final byte of a request.
//   cfg_valid / cfg_ready writes the enter key (reset value CR); cfg_ready
//   is always high.
// timing:
//   a request is taken, then its results are produced one per cycle into
//   the output register while out_stall does not hold it. the enter drain
//   reads the ram one entry a cycle when not stalled, the read address
//   running one step ahead of the emitted byte. ignored bytes (full line,
//   backspace on empty line) produce no result and leave the editor idle.
//   a new request is taken as soon as the last result sits in the output
//   register, even while that result is stalled.
// reset: synchronous, active low; line count cleared, ram left as is.
// stall: out_stall, while out_valid is high, holds the output register and freezes the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_byte,
  output logic            out_port,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  import cle_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINE = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [7:0]    enter_key_r;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  logic          accept;
  logic          slot_free;
  logic          emit;
  logic          wr_en;
  logic [7:0]    rd_data;
  res_t          fix_res;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign fix_res   = fix_result(kind_r, step_r, byte_r);

  assign wr_en = accept && !in_req_type && (in_rx_byte != enter_key_r)
              && (in_rx_byte != CODE_BS) && (in_rx_byte != CODE_DEL)
              && (cnt_r != AW'(LINE_DEPTH - 1));

  // read address runs one step ahead so rd_data always holds entry idx_r
  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r),
    .wr_data (in_rx_byte),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    byte_nxt  = byte_r;
    emit      = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt = in_rx_byte;
          step_nxt = 2'd0;
          idx_nxt  = '0;
          if (in_req_type) begin
            kind_nxt  = KIND_ECHO;
            state_nxt = S_FIX;
          end else if (in_rx_byte == enter_key_r) begin
            kind_nxt = KIND_CRLF;
            if (cnt_r == '0) begin
              state_nxt = S_FIX;
            end else begin
              state_nxt = S_LINE;
            end
          end else if ((in_rx_byte == CODE_BS) || (in_rx_byte == CODE_DEL)) begin
            if (cnt_r != '0) begin
              kind_nxt  = KIND_BS;
              cnt_nxt   = cnt_r - 1'b1;
              state_nxt = S_FIX;
            end
          end else if (wr_en) begin
            kind_nxt  = KIND_ECHO;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_FIX;
          end
        end
      end
      S_LINE: begin
        if (slot_free) begin
          emit    = 1'b1;
          res_nxt = '{data: rd_data, port: PORT_PEER, last: 1'b0};
          if (idx_r == cnt_r - 1'b1) begin
            cnt_nxt   = '0;
            state_nxt = S_FIX;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_FIX: begin
        if (slot_free) begin
          emit     = 1'b1;
          res_nxt  = fix_res;
          step_nxt = step_r + 1'b1;
          if (fix_res.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      enter_key_r <= ENTER_KEY_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        enter_key_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    byte_r <= byte_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = res_r.data;
  assign out_port  = res_r.port;
  assign out_last  = res_r.last;

endmodule

`default_nettype wire

FILE: design/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// port-level checks for the console line editor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "console_line_editor_assert.svh"

module cle_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_port,
  input wire logic       out_last
);

  logic [9:0] out_word;

  assign out_word = {out_byte, out_port, out_last};

  // a stalled result holds
  `CLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // no new request while a request still has results to come
  `CLE_ASSERT_IMPL(a_busy_mid_seq, out_valid && !out_last, in_stall)

  // results of one request follow without gaps
  `CLE_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !out_last, out_valid)

  // every request ends on the console side
  `CLE_ASSERT_IMPL(a_peer_not_last, out_valid && out_port, !out_last)

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

`default_nettype wire

FILE: verif/console_line_editor_tb.sv
// ----------------------------------------------------------------------------
// console_line_editor_tb
// self-checking bench for the console line editor: console and peer bytes
// go in under random source and sink idling, every transmitted byte is
// checked in order against a line-editing predictor across several enter keys
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor_tb;

  import cle_pkg::*;

  localparam int  LINE_DEPTH  = LINE_DEPTH_DEF;
  localparam logic SRC_CONSOLE = 1'b0;
  localparam logic SRC_PEER    = 1'b1;

  // predicts the transmitted bytes of each request and checks them in order
  class line_echo_board;
    logic [7:0] enter_key;
    logic [7:0] line_store [LINE_DEPTH];
    int         line_count;
    res_t       tx_queue [$];
    int         mismatches;

    function new();
      enter_key  = ENTER_KEY_RST;
      line_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return tx_queue.size();
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // returns how many bytes the request is expected to transmit
    function int note_request(input logic src, input logic [7:0] rx);
      res_t burst [$];
      int   k;
      if (src == SRC_PEER) begin
        burst.push_back('{data: rx, port: PORT_CONSOLE, last: 1'b0});
      end else if (rx == enter_key) begin
        for (k = 0; k < line_count; k++) begin
          burst.push_back('{data: line_store[k], port: PORT_PEER, last: 1'b0});
        end
        burst.push_back('{data: CODE_CR, port: PORT_PEER, last: 1'b0});
        burst.push_back('{data: CODE_LF, port: PORT_PEER, last: 1'b0});
        burst.push_back('{data: CODE_CR, port: PORT_CONSOLE, last: 1'b0});
        burst.push_back('{data: CODE_LF, port: PORT_CONSOLE, last: 1'b0});
        line_count = 0;
      end else if (rx == CODE_BS || rx == CODE_DEL) begin
        if (line_count > 0) begin
          line_count--;
          burst.push_back('{data: CODE_BS, port: PORT_CONSOLE, last: 1'b0});
          burst.push_back('{data: CODE_SP, port: PORT_CONSOLE, last: 1'b0});
          burst.push_back('{data: CODE_BS, port: PORT_CONSOLE, last: 1'b0});
        end
      end else if (line_count < LINE_DEPTH - 1) begin
        line_store[line_count] = rx;
        line_count++;
        burst.push_back('{data: rx, port: PORT_CONSOLE, last: 1'b0});
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      for (k = 0; k < burst.size(); k++) tx_queue.push_back(burst[k]);
      return burst.size();
    endfunction

    task check_tx(input logic [7:0] tx_byte, input logic tx_port, input logic tx_last);
      res_t want;
      if (tx_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h to port %0d", tx_byte, tx_port));
        return;
      end
      want = tx_queue.pop_front();
      if (tx_byte !== want.data)
        report_mismatch($sformatf("byte %02h, expected %02h", tx_byte, want.data));
      if (tx_port !== want.port)
        report_mismatch($sformatf("port %0d, expected %0d (byte %02h)",
                                  tx_port, want.port, want.data));
      if (tx_last !== want.last)
        report_mismatch($sformatf("last %0d, expected %0d (byte %02h)",
                                  tx_last, want.last, want.data));
    endtask
  endclass

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic       in_req_type = 1'b0;
  logic [7:0] in_rx_byte  = 8'h00;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       out_port;
  logic       out_last;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data    = 8'h00;

  line_echo_board board;
  bit gaps_on    = 1'b1;
  bit quiet      = 1'b0;
  int stall_left = 0;
  int calm_left  = 0;

  console_line_editor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_port    (out_port),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // sink side: stall bursts with calm stretches in between
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 120);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) board.check_tx(out_byte, out_port, out_last);
  end

  // entered and left at a falling edge
  task automatic send_item(input logic src, input logic [7:0] rx, output bit produced);
    int gap;
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= src;
    in_rx_byte  <= rx;
    do @(posedge clk); while (in_stall !== 1'b0);
    produced = (board.note_request(src, rx) > 0);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic write_enter_key(input logic [7:0] key);
    cfg_valid <= 1'b1;
    cfg_data  <= key;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.enter_key = key;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == board.enter_key || c == CODE_BS || c == CODE_DEL);
    return c;
  endfunction

  // a rub-out code that the current enter key does not shadow
  function automatic logic [7:0] erase_code();
    logic [7:0] c;
    c = $urandom_range(0, 1) ? CODE_BS : CODE_DEL;
    if (c == board.enter_key) c = (c == CODE_BS) ? CODE_DEL : CODE_BS;
    return c;
  endfunction

  // mostly typed lines with corrections, plus peer traffic and noise
  task automatic type_lines(input int n_items);
    int done;
    int len;
    int k;
    int pick;
    bit produced;
    done = 0;
    while (done < n_items) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // long lines run past the end of the line store
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 45) : $urandom_range(0, 8);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) send_item(SRC_CONSOLE, erase_code(), produced);
          else send_item(SRC_CONSOLE, plain_byte(), produced);
          done += produced;
        end
        send_item(SRC_CONSOLE, board.enter_key, produced);
        done += produced;
        if ($urandom_range(0, 19) == 0) hold_until_drained();
      end else if (pick < 8) begin
        send_item(SRC_PEER, 8'($urandom_range(0, 255)), produced);
        done += produced;
      end else if (pick == 8) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), produced);
        done += produced;
      end else begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          send_item(SRC_CONSOLE, erase_code(), produced);
          done += produced;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] key, input int n_items);
    hold_until_drained();
    // ignored bytes may still be in flight
    repeat (8) @(negedge clk);
    write_enter_key(key);
    type_lines(n_items);
  endtask

  initial begin
    bit produced;
    board = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the reset enter key
    send_item(SRC_PEER, 8'h00, produced);
    send_item(SRC_PEER, 8'hFF, produced);
    send_item(SRC_PEER, CODE_CR, produced);
    send_item(SRC_PEER, CODE_BS, produced);
    send_item(SRC_CONSOLE, CODE_CR, produced);     // enter on empty line
    send_item(SRC_CONSOLE, CODE_BS, produced);     // rub-out on empty line
    send_item(SRC_CONSOLE, CODE_DEL, produced);
    send_item(SRC_CONSOLE, 8'h00, produced);
    send_item(SRC_CONSOLE, 8'hFF, produced);
    send_item(SRC_CONSOLE, CODE_LF, produced);
    send_item(SRC_CONSOLE, CODE_SP, produced);
    send_item(SRC_CONSOLE, CODE_BS, produced);
    send_item(SRC_CONSOLE, 8'h55, produced);
    send_item(SRC_CONSOLE, CODE_DEL, produced);
    send_item(SRC_CONSOLE, 8'hAA, produced);
    send_item(SRC_CONSOLE, 8'h7E, produced);
    send_item(SRC_CONSOLE, CODE_CR, produced);

    run_phase(8'h00, 85);
    run_phase(8'hFF, 85);
    run_phase(CODE_BS, 75);                        // enter shadows one rub-out code
    run_phase(CODE_DEL, 75);
    run_phase(8'($urandom_range(0, 255)), 75);
    quiet = 1'b1;
    run_phase(ENTER_KEY_RST, 60);

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (board.pending() != 0) board.report_mismatch("results still expected at end");
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
